### src/fwda_pkg.sv
package fwda_pkg;

  // Largest digit count that is honored; larger counts saturate to it.
  localparam int unsigned MAX_DIGITS = 10;

  // Field widths.
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned BCD_W   = 4;
  localparam int unsigned ASCII_W = 6;
  localparam int unsigned BIT_W   = $clog2(NUM_W);
  localparam int unsigned POS_W   = $clog2(MAX_DIGITS);

  // High bits of the ASCII code for '0'; the low four bits carry the digit.
  localparam logic [ASCII_W-BCD_W-1:0] ASCII_ZERO_HI = 2'b11;

  // Input item.
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [CNT_W-1:0] digit_count;
  } fwda_in_t;

  // Result item, one per emitted digit.
  typedef struct packed {
    logic [ASCII_W-1:0] ascii_digit;
    logic               last_digit;
  } fwda_out_t;

  // Control that every digit cell receives in the same cycle.
  typedef struct packed {
    logic clear;    // load zero at the start of an item
    logic convert;  // one add-3 adjust and shift step
    logic shift;    // move whole digits one cell toward the top
  } fwda_cell_ctl_t;

endpackage

### src/fwda_cell.sv
module fwda_cell (
  input  logic                   clk_i,
  input  fwda_pkg::fwda_cell_ctl_t ctl_i,
  input  logic                   bit_i,
  input  logic [3:0]             digit_i,
  output logic                   bit_o,
  output logic [3:0]             digit_o
);
  import fwda_pkg::*;

  logic [BCD_W-1:0] digit_q, digit_d;
  logic [BCD_W-1:0] adj;

  // Add 3 when the digit would overflow past 9 after doubling.
  always_comb begin
    adj = (digit_q >= BCD_W'(5)) ? digit_q + BCD_W'(3) : digit_q;
  end

  assign bit_o   = adj[BCD_W-1];
  assign digit_o = digit_q;

  // Next digit: clear, double with carry in, or take the neighbor's digit.
  always_comb begin
    digit_d = digit_q;
    if (ctl_i.clear) begin
      digit_d = '0;
    end else if (ctl_i.convert) begin
      digit_d = {adj[BCD_W-2:0], bit_i};
    end else if (ctl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

### src/fixed_width_decimal_ascii.sv
// Converts a 32-bit number to decimal and emits digit_count ASCII digits, MSB first.
// Order: a bit-serial double-dabble pass through the row of ten digit cells, then alignment
// shifts toward the top cell (none for a count of ten), then one digit per cycle; a count
// of zero emits no digits. A new item is accepted only while the block is idle, and busy
// stays high until the last digit has been shown.
// Reset is asynchronous and active low and returns the block to idle; digits cannot stall.
module fixed_width_decimal_ascii (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  fwda_pkg::fwda_in_t  in_i,
  output logic                out_valid_o,
  output fwda_pkg::fwda_out_t out_o
);
  import fwda_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_ALIGN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [NUM_W-1:0] number_q, number_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic [POS_W-1:0] top_q, top_d;
  logic [CNT_W-1:0] count_sat;
  logic             accept;
  fwda_cell_ctl_t   ctl;

  logic                  carry [MAX_DIGITS+1];
  logic [BCD_W-1:0]      digit [MAX_DIGITS+1];

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Counts above the maximum saturate.
  assign count_sat = (in_i.digit_count > CNT_W'(MAX_DIGITS)) ?
                     CNT_W'(MAX_DIGITS) : in_i.digit_count;

  // Control for the digit row.
  always_comb begin
    ctl.clear   = accept;
    ctl.convert = (state_q == ST_CONV);
    ctl.shift   = (state_q == ST_ALIGN) || (state_q == ST_EMIT);
  end

  // Row of digit cells; cell 0 is least significant and the top cell is read out.
  assign carry[0] = number_q[NUM_W-1];
  assign digit[0] = '0;

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    fwda_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .bit_i   (carry[k]),
      .digit_i (digit[k]),
      .bit_o   (carry[k+1]),
      .digit_o (digit[k+1])
    );
  end

  // Sequencer: convert, align the wanted top digit, then emit.
  always_comb begin
    state_d  = state_q;
    number_d = number_q;
    count_d  = count_q;
    bit_d    = bit_q;
    top_d    = top_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d  = ST_CONV;
          number_d = in_i.number;
          count_d  = count_sat;
          bit_d    = '0;
          top_d    = POS_W'(MAX_DIGITS - 1);
        end
      end
      ST_CONV: begin
        number_d = {number_q[NUM_W-2:0], 1'b0};
        bit_d    = bit_q + BIT_W'(1);
        if (bit_q == BIT_W'(NUM_W - 1)) begin
          if (count_q == '0) begin
            state_d = ST_IDLE;
          end else if (count_q == CNT_W'(MAX_DIGITS)) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        top_d = top_q - POS_W'(1);
        if (CNT_W'(top_d) == count_q - CNT_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        count_d = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      bit_q   <= '0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      bit_q   <= bit_d;
      top_q   <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    number_q <= number_d;
  end

  // Each emitted digit is shown for one cycle from the top cell.
  assign out_valid_o       = (state_q == ST_EMIT);
  assign out_o.ascii_digit = {ASCII_ZERO_HI, digit[MAX_DIGITS]};
  assign out_o.last_digit  = (count_q == CNT_W'(1));

endmodule
